// File: src/stft_pkg.sv
// Shared types, character codes and helpers for the exchange-file tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package stft_pkg;

	typedef enum logic [3:0] {
		M_IDLE,
		M_STR,
		M_STRQ,
		M_REF,
		M_NUM,
		M_ENUM,
		M_LABEL,
		M_COMMENT,
		M_COMMENT_STAR,
		M_SKIP
	} mode_t;

	localparam logic [1:0] EV_TOKEN = 2'd0;
	localparam logic [1:0] EV_BYTE  = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;

	localparam logic [3:0] TK_STRING   = 4'd0;
	localparam logic [3:0] TK_REF      = 4'd1;
	localparam logic [3:0] TK_EMPTY    = 4'd2;
	localparam logic [3:0] TK_UNKNOWN  = 4'd3;
	localparam logic [3:0] TK_SET_BEG  = 4'd4;
	localparam logic [3:0] TK_SET_END  = 4'd5;
	localparam logic [3:0] TK_LINE_END = 4'd6;
	localparam logic [3:0] TK_INTEGER  = 4'd7;
	localparam logic [3:0] TK_REAL     = 4'd8;
	localparam logic [3:0] TK_ENUM     = 4'd9;
	localparam logic [3:0] TK_LABEL    = 4'd10;

	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UPPER_E = 8'h45;
	localparam logic [7:0] CH_LOWER_E = 8'h65;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [1:0]  ev;
		logic [3:0]  kind;
		logic [7:0]  pbyte;
		logic [31:0] refnum;
		logic [15:0] len;
		logic        bad;
		logic        last;
	} result_t;

	typedef struct packed {
		result_t res0;
		result_t res1;
		logic    two;
	} entry_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic result_t mk(input logic [1:0] ev, input logic [3:0] kind,
			input logic [7:0] pbyte, input logic [31:0] refnum, input logic [15:0] len);
		result_t r;
		r.ev     = ev;
		r.kind   = kind;
		r.pbyte  = pbyte;
		r.refnum = refnum;
		r.len    = len;
		r.bad    = 1'b0;
		r.last   = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/stft_front.sv
// Scanner front end: classifies each byte, updates scan state, builds result entries.
`timescale 1ns / 1ps
`default_nettype none

module stft_front import stft_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_input,
	output logic            q_push,
	output entry_t          q_din
);

	mode_t       mode_q;
	logic [7:0]  prev_q;
	logic [31:0] ref_q;
	logic [15:0] len_q;
	logic        frac_q;

	mode_t       mode_a, mode_n;
	logic [31:0] ref_a, ref_n;
	logic [15:0] len_a, len_n;
	logic        frac_a, frac_n;
	logic [7:0]  prev_n;
	result_t     a0, a1, d0, d1, e0, r0, r1;
	logic [1:0]  na, nd, nsum, n;
	logic        redo, skip_err, ctrl_err, err, has_end;
	logic [7:0]  c;

	assign c = text_byte;

	always_comb begin
		a0 = '0;
		a1 = '0;
		na = 2'd0;
		redo = 1'b0;
		skip_err = 1'b0;
		mode_a = mode_q;
		ref_a = ref_q;
		len_a = len_q;
		frac_a = frac_q;
		unique case (mode_q)
			M_STR: begin
				if (c == CH_QUOTE) begin
					mode_a = M_STRQ;
				end else begin
					len_a = len_q + 16'd1;
					a0 = mk(EV_BYTE, TK_STRING, c, '0, '0);
					na = 2'd1;
				end
			end
			M_STRQ: begin
				if (c == CH_QUOTE) begin
					len_a = len_q + 16'd2;
					a0 = mk(EV_BYTE, TK_STRING, CH_QUOTE, '0, '0);
					a1 = a0;
					na = 2'd2;
					mode_a = M_STR;
				end else begin
					a0 = mk(EV_END, TK_STRING, '0, '0, len_q);
					na = 2'd1;
					redo = 1'b1;
				end
			end
			M_REF: begin
				if (is_digit(c)) begin
					ref_a = {ref_q[28:0], 3'b000} + {ref_q[30:0], 1'b0} + {28'd0, c[3:0]};
				end else begin
					a0 = mk(EV_TOKEN, TK_REF, '0, ref_q, '0);
					na = 2'd1;
					redo = 1'b1;
				end
			end
			M_NUM: begin
				if (is_digit(c) || c == CH_DOT || c == CH_UPPER_E || c == CH_LOWER_E
						|| c == CH_MINUS || c == CH_PLUS) begin
					frac_a = frac_q | (c == CH_DOT) | (c == CH_UPPER_E);
					len_a = len_q + 16'd1;
					a0 = mk(EV_BYTE, frac_a ? TK_REAL : TK_INTEGER, c, '0, '0);
					na = 2'd1;
				end else begin
					a0 = mk(EV_END, frac_q ? TK_REAL : TK_INTEGER, '0, '0, len_q);
					na = 2'd1;
					redo = 1'b1;
				end
			end
			M_ENUM: begin
				if (c == CH_DOT) begin
					a0 = mk(EV_END, TK_ENUM, '0, '0, len_q);
					na = 2'd1;
					mode_a = M_IDLE;
					len_a = '0;
					ref_a = '0;
					frac_a = 1'b0;
				end else begin
					len_a = len_q + 16'd1;
					a0 = mk(EV_BYTE, TK_ENUM, c, '0, '0);
					na = 2'd1;
				end
			end
			M_LABEL: begin
				if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
					len_a = len_q + 16'd1;
					a0 = mk(EV_BYTE, TK_LABEL, c, '0, '0);
					na = 2'd1;
				end else begin
					a0 = mk(EV_END, TK_LABEL, '0, '0, len_q);
					na = 2'd1;
					redo = 1'b1;
				end
			end
			M_COMMENT: begin
				if (c == CH_STAR) mode_a = M_COMMENT_STAR;
			end
			M_COMMENT_STAR: begin
				if (c == CH_SLASH) mode_a = M_IDLE;
				else if (c != CH_STAR) mode_a = M_COMMENT;
			end
			M_SKIP: begin
				if (c == CH_SEMI) begin
					skip_err = 1'b1;
					a0 = mk(EV_TOKEN, TK_LINE_END, '0, '0, '0);
					na = 2'd1;
					mode_a = M_IDLE;
				end else if (c == CH_LF) begin
					mode_a = M_IDLE;
				end
			end
			default: begin
				redo = 1'b1;
			end
		endcase
	end

	always_comb begin
		d0 = '0;
		d1 = '0;
		nd = 2'd0;
		ctrl_err = 1'b0;
		mode_n = M_IDLE;
		len_n = '0;
		ref_n = '0;
		frac_n = 1'b0;
		priority if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
		end else if (c == CH_QUOTE) begin
			mode_n = M_STR;
		end else if (c == CH_HASH) begin
			mode_n = M_REF;
		end else if (c == CH_DOLLAR) begin
			d0 = mk(EV_TOKEN, TK_EMPTY, '0, '0, '0);
			nd = 2'd1;
		end else if (c == CH_STAR) begin
			if (prev_q == CH_SLASH) begin
				mode_n = M_COMMENT;
			end else begin
				d0 = mk(EV_TOKEN, TK_UNKNOWN, '0, '0, '0);
				nd = 2'd1;
			end
		end else if (c == CH_LPAREN) begin
			d0 = mk(EV_TOKEN, TK_SET_BEG, '0, '0, '0);
			nd = 2'd1;
		end else if (c == CH_RPAREN) begin
			d0 = mk(EV_TOKEN, TK_SET_END, '0, '0, '0);
			nd = 2'd1;
		end else if (c == CH_SEMI) begin
			d0 = mk(EV_TOKEN, TK_LINE_END, '0, '0, '0);
			nd = 2'd1;
		end else if (c == CH_DOT) begin
			mode_n = M_ENUM;
		end else if (is_digit(c)) begin
			mode_n = M_NUM;
			if (prev_q == CH_MINUS) begin
				d0 = mk(EV_BYTE, TK_INTEGER, CH_MINUS, '0, '0);
				d1 = mk(EV_BYTE, TK_INTEGER, c, '0, '0);
				nd = 2'd2;
				len_n = 16'd2;
			end else begin
				d0 = mk(EV_BYTE, TK_INTEGER, c, '0, '0);
				nd = 2'd1;
				len_n = 16'd1;
			end
		end else if (is_alpha(c)) begin
			mode_n = M_LABEL;
			d0 = mk(EV_BYTE, TK_LABEL, c, '0, '0);
			nd = 2'd1;
			len_n = 16'd1;
		end else if (c < CH_SPACE) begin
			ctrl_err = 1'b1;
			mode_n = M_SKIP;
		end
		if (!redo) begin
			d0 = '0;
			d1 = '0;
			nd = 2'd0;
			ctrl_err = 1'b0;
			mode_n = mode_a;
			len_n = len_a;
			ref_n = ref_a;
			frac_n = frac_a;
		end
	end

	always_comb begin
		has_end = 1'b1;
		e0 = '0;
		unique case (mode_q)
			M_STR, M_STRQ: e0 = mk(EV_END, TK_STRING, '0, '0, len_q);
			M_NUM:         e0 = mk(EV_END, frac_q ? TK_REAL : TK_INTEGER, '0, '0, len_q);
			M_ENUM:        e0 = mk(EV_END, TK_ENUM, '0, '0, len_q);
			M_LABEL:       e0 = mk(EV_END, TK_LABEL, '0, '0, len_q);
			M_REF:         e0 = mk(EV_TOKEN, TK_REF, '0, ref_q, '0);
			default:       has_end = 1'b0;
		endcase
	end

	always_comb begin
		nsum = (na == 2'd0) ? nd : ((na == 2'd1 && nd != 2'd0) ? 2'd2 : na);
		err = skip_err | ctrl_err;
		if (end_of_input) begin
			r0 = e0;
			r1 = '0;
			n = {1'b0, has_end};
			err = 1'b0;
		end else begin
			r0 = (na != 2'd0) ? a0 : d0;
			r1 = (na == 2'd2) ? a1 : ((na == 2'd1) ? d0 : d1);
			n = nsum;
		end
		r0.bad = err;
		r1.bad = err;
		r0.last = (n == 2'd1);
		r1.last = 1'b1;
		q_din.res0 = r0;
		q_din.res1 = r1;
		q_din.two = (n == 2'd2);
		q_push = accept && (n != 2'd0);
		prev_n = end_of_input ? 8'd0 : c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			prev_q <= '0;
			ref_q <= '0;
			len_q <= '0;
			frac_q <= 1'b0;
		end else if (accept) begin
			prev_q <= prev_n;
			if (end_of_input) begin
				mode_q <= M_IDLE;
				ref_q <= '0;
				len_q <= '0;
				frac_q <= 1'b0;
			end else begin
				mode_q <= mode_n;
				ref_q <= ref_n;
				len_q <= len_n;
				frac_q <= frac_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/stft_queue.sv
// Short queue of result entries between scanner and result sequencer.
`timescale 1ns / 1ps
`default_nettype none

module stft_queue import stft_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t din,
	output logic        full,
	input  wire logic   pop,
	output entry_t      dout,
	output logic        empty
);

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push, do_pop;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("queue count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + (QAW+1)'(1)))
		else $error("queue count did not grow on push");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - (QAW+1)'(1)))
		else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

// File: src/stft_back.sv
// Result sequencer: hands out the one or two results of each queued entry in order.
`timescale 1ns / 1ps
`default_nettype none

module stft_back import stft_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire entry_t head,
	input  wire logic   q_empty,
	output logic        q_pop,
	input  wire logic   pop,
	output logic        empty,
	output result_t     res
);

	logic sel_q;
	logic take;

	assign empty = q_empty;
	assign take  = pop && !q_empty;
	assign q_pop = take && (sel_q || !head.two);
	assign res   = sel_q ? head.res1 : head.res0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= !sel_q && head.two;
		end
	end

	a_second_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && sel_q) |-> head.two)
		else $error("second result selected on a single-result entry");

endmodule

`default_nettype wire

// File: src/step_file_tokenizer.sv
// Top level of the exchange-file tokenizer: scanner, entry queue and result sequencer.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------------
//  input    | push / full       | text_byte, end_of_input
//  result   | empty / pop       | event_kind, token_kind, payload_byte, ref_number,
//           |                   | payload_length, bad_control, last_of_run
//
//  One input byte is taken per cycle while full is low; the scan state updates in
//  the same cycle. Each byte gives zero, one or two results, drained at one result
//  per cycle. Byte rate is sustained while results average at most one per byte;
//  the four-entry queue absorbs bursts and full rises only when it fills.
//  Reset (arst_n low) returns the scanner to idle and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module step_file_tokenizer import stft_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_input,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       event_kind,
	output logic [3:0]       token_kind,
	output logic [7:0]       payload_byte,
	output logic [31:0]      ref_number,
	output logic [15:0]      payload_length,
	output logic             bad_control,
	output logic             last_of_run
);

	logic    accept;
	logic    q_push, q_pop, q_empty;
	entry_t  q_din, q_head;
	result_t res;

	assign accept = push && !full;

	stft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.q_push       (q_push),
		.q_din        (q_din)
	);

	stft_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (full),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty)
	);

	stft_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign event_kind     = res.ev;
	assign token_kind     = res.kind;
	assign payload_byte   = res.pbyte;
	assign ref_number     = res.refnum;
	assign payload_length = res.len;
	assign bad_control    = res.bad;
	assign last_of_run    = res.last;

endmodule

`default_nettype wire
